FILE: rtl/xsb_pkg.sv
// ----------------------------------------------------------------------------
// xsb_pkg: shared types and constants of the xorshift1024* byte source
// Holds the seed table, the multiplier halves and the interface structs.
// ----------------------------------------------------------------------------
package xsb_pkg;

    localparam int CNT_W  = 7;
    localparam int WORD_W = 64;
    localparam int BYTE_W = 8;

    // Multiplier of the output scrambler, split into 32-bit halves.
    localparam logic [31:0] MULT_LO = 32'h5497_FDB5;
    localparam logic [31:0] MULT_HI = 32'h1066_89D4;

    // Pool contents after reset, oldest index first.
    localparam logic [WORD_W-1:0] SEED_INIT [16] = '{
        64'h84242f96eca9c41d, 64'ha3c65b8776f96855,
        64'h5b34a39f070b5837, 64'h4489affce4f31a1e,
        64'h2ffeeb0a48316f40, 64'hdc2d9891fe68c022,
        64'h3659132bb12fea70, 64'haac17d8efa43cab8,
        64'hc4cb815590989b13, 64'h5ee975283d71c93b,
        64'h691548c86c1bd540, 64'h7910c41d10a1e6a5,
        64'h0b5fc64563b3e2a8, 64'h047f7684e9fc949d,
        64'hb99181f2d8f685ca, 64'h284600e3f30e38c3
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAW,
        ST_EMIT
    } t_state;

    // Request handed from the front queue to the back sequencer.
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
    } t_req;

    // Fresh word from the generator.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } t_gen;

endpackage

FILE: rtl/xorshift1024star_byte_source.sv
// ----------------------------------------------------------------------------
// xorshift1024star_byte_source: random byte source on xorshift1024*
// Takes read requests for a byte count and returns that many random bytes.
// ----------------------------------------------------------------------------
// Each pushed transaction asks for byte_count random bytes (clamped to
// MAX_READ); a count of zero is accepted and produces nothing. The bytes come
// out as separate result transactions, least significant byte of each 64-bit
// word first, with o_is_last set on the final byte of the request. Unused
// bytes of the last word are kept: a later request that fits inside them is
// served from that word, otherwise they are dropped and fresh words are
// drawn. The generator state resets to fixed seeds, so the sequence after
// reset is always the same. Timing: the sequencer handles one request at a
// time and moves one byte per cycle while the result queue has room and no
// word is being drawn. After its start pulse a fresh word passes the pool
// step, two multiply stages and the load into the held word. The start for
// the first word goes out in the same cycle that takes the request, and the
// start for each later word goes out with the last byte of the previous
// word, so a word drawn in the middle of a request leaves a gap in the bytes.
// A two-entry request queue and a two-entry result queue let the input and
// output sides stall independently of the sequencer.
// ----------------------------------------------------------------------------
module xorshift1024star_byte_source import xsb_pkg::*; #(
    parameter int MAX_READ = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CNT_W-1:0]  i_byte_count,
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] o_random_byte,
    output logic              o_is_last
);

    t_req w_req;
    logic w_req_pop;
    logic w_start;
    t_gen w_gen;

    // Front end: clamps the count, drops empty requests, queues the rest.
    xsb_front #(
        .MAX_READ (MAX_READ)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_byte_count (i_byte_count),
        .o_req        (w_req),
        .i_req_pop    (w_req_pop)
    );

    // Word generator: advances the pool one step per start pulse.
    xsb_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .o_gen   (w_gen)
    );

    // Back end: decides between held bytes and fresh words, emits bytes.
    xsb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (w_req),
        .o_req_pop     (w_req_pop),
        .o_start       (w_start),
        .i_gen         (w_gen),
        .empty         (empty),
        .pop           (pop),
        .o_random_byte (o_random_byte),
        .o_is_last     (o_is_last)
    );

endmodule

FILE: rtl/xsb_front.sv
// ----------------------------------------------------------------------------
// xsb_front: request intake
// Clamps the byte count, drops empty requests and queues the rest.
// ----------------------------------------------------------------------------
module xsb_front import xsb_pkg::*; #(
    parameter int MAX_READ = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [CNT_W-1:0] i_byte_count,
    output t_req             o_req,
    input  logic             i_req_pop
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_READ);

    logic [CNT_W-1:0] r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_fill, n_fill;
    logic [CNT_W-1:0] w_cnt;
    logic             w_store;

    assign w_cnt   = (i_byte_count > MAX_CNT) ? MAX_CNT : i_byte_count;
    assign full    = (r_fill == 2'd2);
    assign w_store = push && !full && (w_cnt != '0);

    always_comb begin
        n_fill = r_fill;
        if (w_store && !i_req_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (!w_store && i_req_pop) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            r_fill <= n_fill;
            if (w_store) begin
                r_wp <= ~r_wp;
            end
            if (i_req_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_q[r_wp] <= w_cnt;
        end
    end

    assign o_req.valid = (r_fill != 2'd0);
    assign o_req.count = r_q[r_rp];

endmodule

FILE: rtl/xsb_gen.sv
// ----------------------------------------------------------------------------
// xsb_gen: xorshift1024* word generator
// Rotating 16-word pool, one xorshift step, then a two-stage multiply.
// ----------------------------------------------------------------------------
module xsb_gen import xsb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output t_gen o_gen
);

    // r_pool[0] is the word at the current pool index, r_pool[1] the next one.
    logic [WORD_W-1:0] r_pool [16];
    logic [WORD_W-1:0] w_t, n_s;
    logic [WORD_W-1:0] r_s;
    logic [WORD_W-1:0] r_p0;
    logic [31:0]       r_p1, r_p2;
    logic [WORD_W-1:0] r_word;
    logic              r_v1, r_v2, r_v3;

    assign w_t = r_pool[1] ^ (r_pool[1] << 31);
    assign n_s = w_t ^ r_pool[0] ^ (w_t >> 11) ^ (r_pool[0] >> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= SEED_INIT;
        end else if (i_start) begin
            r_pool[0]  <= n_s;
            for (int i = 1; i < 15; i++) begin
                r_pool[i] <= r_pool[i+1];
            end
            r_pool[15] <= r_pool[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Product modulo 2^64 from three 32x32 partial products.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_s <= n_s;
        end
        r_p0   <= WORD_W'(r_s[31:0]) * WORD_W'(MULT_LO);
        r_p1   <= 32'(r_s[63:32] * MULT_LO);
        r_p2   <= 32'(r_s[31:0] * MULT_HI);
        r_word <= r_p0 + {r_p1 + r_p2, 32'd0};
    end

    assign o_gen.valid = r_v3;
    assign o_gen.word  = r_word;

endmodule

FILE: rtl/xsb_back.sv
// ----------------------------------------------------------------------------
// xsb_back: byte sequencer and result queue
// Serves bytes from the held word or draws fresh words, one byte a cycle while the result queue has room.
// ----------------------------------------------------------------------------
module xsb_back import xsb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_req              i_req,
    output logic              o_req_pop,
    output logic              o_start,
    input  t_gen              i_gen,
    output logic              empty,
    input  logic              pop,
    output logic [BYTE_W-1:0] o_random_byte,
    output logic              o_is_last
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [2:0]        r_pos, n_pos;
    logic [3:0]        r_left, n_left;
    logic [WORD_W-1:0] r_held, n_held;
    logic              w_emit;
    logic [BYTE_W-1:0] w_byte;
    logic              w_last;

    logic [BYTE_W-1:0] r_ob_byte [2];
    logic              r_ob_last [2];
    logic              r_ob_wp, r_ob_rp;
    logic [1:0]        r_ob_fill;
    logic              w_ob_pop;

    assign w_byte = r_held[{r_pos, 3'b000} +: BYTE_W];
    assign w_last = (r_rem == CNT_W'(1));

    always_comb begin
        n_state   = r_state;
        n_rem     = r_rem;
        n_pos     = r_pos;
        n_left    = r_left;
        n_held    = r_held;
        o_req_pop = 1'b0;
        o_start   = 1'b0;
        w_emit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    o_req_pop = 1'b1;
                    n_rem     = i_req.count;
                    if (CNT_W'(r_left) >= i_req.count) begin
                        n_pos   = 3'(4'd8 - r_left);
                        n_state = ST_EMIT;
                    end else begin
                        o_start = 1'b1;
                        n_state = ST_DRAW;
                    end
                end
            end
            ST_DRAW: begin
                if (i_gen.valid) begin
                    n_held  = i_gen.word;
                    n_pos   = 3'd0;
                    n_left  = 4'd8;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_ob_fill != 2'd2) begin
                    w_emit = 1'b1;
                    n_rem  = r_rem - CNT_W'(1);
                    n_pos  = r_pos + 3'd1;
                    n_left = r_left - 4'd1;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else if (r_pos == 3'd7) begin
                        o_start = 1'b1;
                        n_state = ST_DRAW;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_left  <= 4'd0;
            r_held  <= '0;
            r_rem   <= '0;
            r_pos   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_held  <= n_held;
            r_rem   <= n_rem;
            r_pos   <= n_pos;
        end
    end

    // Two-entry result queue.
    assign w_ob_pop = pop && !empty;
    assign empty    = (r_ob_fill == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wp   <= 1'b0;
            r_ob_rp   <= 1'b0;
            r_ob_fill <= 2'd0;
        end else begin
            if (w_emit) begin
                r_ob_wp <= ~r_ob_wp;
            end
            if (w_ob_pop) begin
                r_ob_rp <= ~r_ob_rp;
            end
            if (w_emit && !w_ob_pop) begin
                r_ob_fill <= r_ob_fill + 2'd1;
            end else if (!w_emit && w_ob_pop) begin
                r_ob_fill <= r_ob_fill - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_ob_byte[r_ob_wp] <= w_byte;
            r_ob_last[r_ob_wp] <= w_last;
        end
    end

    assign o_random_byte = r_ob_byte[r_ob_rp];
    assign o_is_last     = r_ob_last[r_ob_rp];

`ifndef ASSERT_OFF
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 4'd8)
        else $error("held byte count above eight");

    a_word_in_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_gen.valid |-> (r_state == ST_DRAW))
        else $error("fresh word arrived outside the draw state");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (r_ob_fill != 2'd2))
        else $error("byte written into a full result queue");

    a_start_then_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_start |-> ##3 i_gen.valid)
        else $error("word generator missed its latency");
`endif

endmodule
